### sv/qecm_pkg.sv
//------------------------------------------------------------------------------
// qecm_pkg: shared types and constants of the element conduction matrix
// Gauss rule tables, register indexes, field widths.
//------------------------------------------------------------------------------
package qecm_pkg;

    localparam int MAX_ORDER = 4;
    localparam int FRAC_BITS = 16;
    localparam int SH        = FRAC_BITS + 2;
    localparam int VAL_W     = 48;

    localparam logic [0:0] REG_CONDUCTIVITY = 1'b0;
    localparam logic [0:0] REG_QUAD_ORDER   = 1'b1;

    localparam logic [63:0] TERM_CAP = 64'd1 << 50;

    // Gauss points and weights, rounded to Q(FRAC_BITS)
    localparam logic [31:0] PT_ORDER2 =
        32'(((64'd577350269 << FRAC_BITS) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] PT_ORDER3 =
        32'(((64'd774596669 << FRAC_BITS) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] PT_OUTER4 =
        32'(((64'd861136312 << FRAC_BITS) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] PT_INNER4 =
        32'(((64'd339981044 << FRAC_BITS) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] WT_OUTER4 =
        32'(((64'd347854845 << FRAC_BITS) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] WT_INNER4 =
        32'(((64'd652145155 << FRAC_BITS) + 64'd500000000) / 64'd1000000000);
    localparam logic [31:0] WT_OUTER3 = 32'(((64'd5 << FRAC_BITS) + 64'd4) / 64'd9);
    localparam logic [31:0] WT_INNER3 = 32'(((64'd8 << FRAC_BITS) + 64'd4) / 64'd9);

    typedef struct packed {
        logic signed [31:0] node0_x;
        logic signed [31:0] node0_y;
        logic signed [31:0] node1_x;
        logic signed [31:0] node1_y;
        logic signed [31:0] node2_x;
        logic signed [31:0] node2_y;
        logic signed [31:0] node3_x;
        logic signed [31:0] node3_y;
    } in_word_t;

    typedef struct packed {
        logic [1:0]              row;
        logic [1:0]              col;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } out_word_t;

    // Gauss point number k of an order
    function automatic logic signed [31:0] gauss_pt(input logic [2:0] n, input logic [1:0] k);
        logic signed [31:0] p;
        logic signed [31:0] q;
        p = 32'sd0;
        unique case (n)
            3'd2:
            begin
                p = $signed(PT_ORDER2);
                return (k == 2'd0) ? -p : p;
            end
            3'd3:
            begin
                p = $signed(PT_ORDER3);
                return (k == 2'd0) ? -p : ((k == 2'd1) ? 32'sd0 : p);
            end
            3'd4:
            begin
                p = $signed(PT_OUTER4);
                q = $signed(PT_INNER4);
                unique case (k)
                    2'd0: return -p;
                    2'd1: return -q;
                    2'd2: return q;
                    default: return p;
                endcase
            end
            default: return p;
        endcase
    endfunction

    function automatic logic [31:0] gauss_wt(input logic [2:0] n, input logic [1:0] k);
        unique case (n)
            3'd2: return 32'd1 << FRAC_BITS;
            3'd3: return (k == 2'd1) ? WT_INNER3 : WT_OUTER3;
            3'd4: return (k == 2'd0 || k == 2'd3) ? WT_OUTER4 : WT_INNER4;
            default: return 32'd0;
        endcase
    endfunction

endpackage

### sv/qecm_if.sv
//------------------------------------------------------------------------------
// qecm_in_if / qecm_out_if: valid/ready channels
// One word moves when valid and ready are both high.
//------------------------------------------------------------------------------
interface qecm_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] node0_x;
    logic signed [31:0] node0_y;
    logic signed [31:0] node1_x;
    logic signed [31:0] node1_y;
    logic signed [31:0] node2_x;
    logic signed [31:0] node2_y;
    logic signed [31:0] node3_x;
    logic signed [31:0] node3_y;
    modport source (output valid, node0_x, node0_y, node1_x, node1_y,
                    node2_x, node2_y, node3_x, node3_y, input ready);
    modport sink (input valid, node0_x, node0_y, node1_x, node1_y,
                  node2_x, node2_y, node3_x, node3_y, output ready);
endinterface

interface qecm_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [47:0] value;
    logic               last;
    modport source (output valid, row, col, value, last, input ready);
    modport sink (input valid, row, col, value, last, output ready);
endinterface

### sv/qecm_div.sv
//------------------------------------------------------------------------------
// qecm_div: restoring divider, one quotient bit a cycle
// 128-bit dividend by 64-bit divisor, quotient capped.
//------------------------------------------------------------------------------
module qecm_div
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] dividend,
    input  logic [63:0]  divisor,
    output logic         done,
    output logic [63:0]  quotient
);
    logic [127:0] dvd_reg, dvd_next;
    logic [64:0]  rem_reg, rem_next;
    logic [63:0]  q_reg, q_next;
    logic [63:0]  d_reg;
    logic [7:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         capped_reg, capped_next;
    logic [64:0]  shifted;
    logic [64:0]  qs;

    always_comb
    begin
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        capped_next = capped_reg;
        shifted     = {rem_reg[63:0], dvd_reg[127]};
        qs          = {q_reg, 1'b0};
        done        = 1'b0;
        if (start)
        begin
            dvd_next    = dividend;
            rem_next    = '0;
            q_next      = '0;
            cnt_next    = 8'd128;
            busy_next   = 1'b1;
            capped_next = 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[126:0], 1'b0};
            if (shifted >= {1'b0, d_reg})
            begin
                rem_next = shifted - {1'b0, d_reg};
                qs[0]    = 1'b1;
            end
            else
                rem_next = shifted;
            if (!capped_reg)
            begin
                if (qs > {1'b0, qecm_pkg::TERM_CAP})
                begin
                    capped_next = 1'b1;
                    q_next      = qecm_pkg::TERM_CAP;
                end
                else
                    q_next = qs[63:0];
            end
            cnt_next = cnt_reg - 8'd1;
            if (cnt_reg == 8'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quotient = q_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            capped_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            capped_reg <= capped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
            d_reg <= divisor;
    end
endmodule

### sv/qecm_core.sv
//------------------------------------------------------------------------------
// qecm_core: sequencer around one shared 33x33 multiplier
// Walks Gauss points, Jacobian, adjugate terms and 16 entries per point of non-zero determinant.
//------------------------------------------------------------------------------
module qecm_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          conductivity,
    input  logic [2:0]           quad_order,
    qecm_in_if.sink              in_ch,
    qecm_out_if.source           out_ch
);
    typedef enum logic [3:0] {
        S_IDLE, S_PT, S_JAC, S_JRND, S_DET, S_UV, S_KW, S_MUL, S_MUL2, S_SCALE,
        S_DIV, S_ACC, S_OUT
    } state_t;

    state_t state_reg;

    logic signed [31:0] x_reg [4];
    logic signed [31:0] y_reg [4];
    logic signed [63:0] acc_reg [16];
    logic signed [63:0] da_reg [4];
    logic signed [63:0] db_reg [4];
    logic signed [63:0] s_reg [4];
    logic signed [63:0] j_reg [4];
    logic signed [63:0] u_reg [4];
    logic signed [63:0] v_reg [4];
    logic signed [63:0] det_reg;
    logic signed [63:0] num_reg;
    logic [63:0]        kw_reg;
    logic [127:0]       prod_reg;
    logic [1:0]         ie_reg, ix_reg, ci_reg, cj_reg;
    logic [3:0]         step_reg;
    logic [3:0]         oi_reg;
    logic [2:0]         n_reg;
    logic               neg_reg;

    logic signed [65:0]  mul_p;
    logic signed [32:0]  ma, mb;
    logic                div_start, div_done;
    logic [63:0]         div_q;
    logic [63:0]         adet;
    logic [63:0]         anum;

    // shared multiplier
    assign mul_p = ma * mb;

    function automatic logic signed [63:0] shr_round(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (qecm_pkg::SH - 1))) >> qecm_pkg::SH;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [63:0] sat_j(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483647) return -64'sd2147483647;
        return v;
    endfunction

    assign adet = det_reg[63] ? 64'(-det_reg) : 64'(det_reg);
    assign anum = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            S_JAC:
            begin
                ma = 33'(da_reg[step_reg[3:2]]);
                mb = step_reg[0] ? 33'(y_reg[step_reg[3:2]]) : 33'(x_reg[step_reg[3:2]]);
                if (step_reg[1]) ma = 33'(db_reg[step_reg[3:2]]);
            end
            S_DET:
            begin
                ma = step_reg[0] ? 33'(j_reg[1]) : 33'(j_reg[0]);
                mb = step_reg[0] ? 33'(j_reg[2]) : 33'(j_reg[3]);
            end
            S_UV:
            begin
                unique case (step_reg[1:0])
                    2'd0: begin ma = 33'(j_reg[3]); mb = 33'(da_reg[step_reg[3:2]]); end
                    2'd1: begin ma = 33'(j_reg[1]); mb = 33'(db_reg[step_reg[3:2]]); end
                    2'd2: begin ma = 33'(j_reg[0]); mb = 33'(db_reg[step_reg[3:2]]); end
                    default: begin ma = 33'(j_reg[2]); mb = 33'(da_reg[step_reg[3:2]]); end
                endcase
            end
            S_KW:
            begin
                ma = 33'(qecm_pkg::gauss_wt(n_reg, ie_reg));
                mb = 33'(qecm_pkg::gauss_wt(n_reg, ix_reg));
                if (step_reg[0])
                begin
                    ma = 33'(kw_reg);
                    mb = {1'b0, conductivity};
                end
            end
            S_MUL:
            begin
                ma = step_reg[0] ? 33'(v_reg[ci_reg]) : 33'(u_reg[ci_reg]);
                mb = step_reg[0] ? 33'(v_reg[cj_reg]) : 33'(u_reg[cj_reg]);
            end
            S_MUL2:
            begin
                // partial products: lo*lo, lo*hi, hi*lo, hi*hi
                ma = {1'b0, step_reg[1] ? anum[63:32] : anum[31:0]};
                mb = {1'b0, step_reg[0] ? kw_reg[63:32] : kw_reg[31:0]};
            end
            default: ;
        endcase
    end

    assign div_start = (state_reg == S_SCALE);

    qecm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg >> (qecm_pkg::FRAC_BITS - 8)),
        .divisor  (adet),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.row   = oi_reg[3:2];
    assign out_ch.col   = oi_reg[1:0];
    assign out_ch.last  = (oi_reg == 4'd15);
    always_comb
    begin
        if (acc_reg[oi_reg] > 64'sh7FFF_FFFF_FFFF)
            out_ch.value = 48'sh7FFF_FFFF_FFFF;
        else if (acc_reg[oi_reg] < -64'sh8000_0000_0000)
            out_ch.value = 48'sh8000_0000_0000;
        else
            out_ch.value = acc_reg[oi_reg][47:0];
    end

    logic signed [63:0] one, xi, eta;
    assign one = 64'sd1 <<< qecm_pkg::FRAC_BITS;
    assign xi  = 64'(qecm_pkg::gauss_pt(n_reg, ix_reg));
    assign eta = 64'(qecm_pkg::gauss_pt(n_reg, ie_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            oi_reg    <= '0;
            ie_reg    <= '0;
            ix_reg    <= '0;
            ci_reg    <= '0;
            cj_reg    <= '0;
            n_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_ch.valid)
                    begin
                        x_reg[0] <= in_ch.node0_x; y_reg[0] <= in_ch.node0_y;
                        x_reg[1] <= in_ch.node1_x; y_reg[1] <= in_ch.node1_y;
                        x_reg[2] <= in_ch.node2_x; y_reg[2] <= in_ch.node2_y;
                        x_reg[3] <= in_ch.node3_x; y_reg[3] <= in_ch.node3_y;
                        for (int k = 0; k < 16; k++) acc_reg[k] <= '0;
                        n_reg  <= quad_order;
                        ie_reg <= '0;
                        ix_reg <= '0;
                        oi_reg <= '0;
                        if (quad_order < 3'd2 || quad_order > 3'(qecm_pkg::MAX_ORDER))
                            state_reg <= S_OUT;
                        else
                            state_reg <= S_PT;
                    end
                S_PT:
                begin
                    da_reg[0] <= -(one - eta); da_reg[1] <= one - eta;
                    da_reg[2] <= one + eta;    da_reg[3] <= -(one + eta);
                    db_reg[0] <= -(one - xi);  db_reg[1] <= -(one + xi);
                    db_reg[2] <= one + xi;     db_reg[3] <= one - xi;
                    for (int k = 0; k < 4; k++) s_reg[k] <= '0;
                    step_reg  <= '0;
                    state_reg <= S_JAC;
                end
                S_JAC:
                begin
                    // step: node[3:2], use db[1], use y[0]
                    s_reg[step_reg[1:0]] <= s_reg[step_reg[1:0]] + mul_p[63:0];
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd15) state_reg <= S_JRND;
                end
                S_JRND:
                begin
                    for (int k = 0; k < 4; k++) j_reg[k] <= sat_j(shr_round(s_reg[k]));
                    step_reg  <= '0;
                    state_reg <= S_DET;
                end
                S_DET:
                begin
                    if (!step_reg[0])
                    begin
                        det_reg  <= mul_p[63:0];
                        step_reg <= 4'd1;
                    end
                    else
                    begin
                        det_reg  <= det_reg - mul_p[63:0];
                        step_reg <= '0;
                        if (det_reg == mul_p[63:0])
                            state_reg <= S_ACC;
                        else
                            state_reg <= S_UV;
                    end
                end
                S_UV:
                begin
                    unique case (step_reg[1:0])
                        2'd0: u_reg[step_reg[3:2]] <= mul_p[63:0];
                        2'd1: u_reg[step_reg[3:2]] <= shr_round(u_reg[step_reg[3:2]] - mul_p[63:0]);
                        2'd2: v_reg[step_reg[3:2]] <= mul_p[63:0];
                        default: v_reg[step_reg[3:2]] <= shr_round(v_reg[step_reg[3:2]] - mul_p[63:0]);
                    endcase
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'd15)
                        state_reg <= S_KW;
                end
                S_KW:
                begin
                    if (!step_reg[0])
                    begin
                        kw_reg   <= (mul_p[63:0] + (64'd1 << (qecm_pkg::FRAC_BITS - 1)))
                                    >> qecm_pkg::FRAC_BITS;
                        step_reg <= 4'd1;
                    end
                    else
                    begin
                        kw_reg    <= mul_p[63:0];
                        step_reg  <= '0;
                        ci_reg    <= '0;
                        cj_reg    <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (!step_reg[0])
                    begin
                        num_reg  <= mul_p[63:0];
                        step_reg <= 4'd1;
                    end
                    else
                    begin
                        num_reg   <= num_reg + mul_p[63:0];
                        step_reg  <= '0;
                        state_reg <= S_MUL2;
                    end
                end
                S_MUL2:
                begin
                    unique case (step_reg[1:0])
                        2'd0:
                        begin
                            prod_reg <= {64'd0, mul_p[63:0]};
                            step_reg <= step_reg + 4'd1;
                        end
                        2'd1, 2'd2:
                        begin
                            prod_reg <= prod_reg + {32'd0, mul_p[63:0], 32'd0};
                            step_reg <= step_reg + 4'd1;
                        end
                        default:
                        begin
                            prod_reg  <= prod_reg + {mul_p[63:0], 64'd0};
                            neg_reg   <= num_reg[63] ^ det_reg[63];
                            step_reg  <= '0;
                            state_reg <= S_SCALE;
                        end
                    endcase
                end
                S_SCALE:
                    state_reg <= S_DIV;
                S_DIV:
                    if (div_done)
                    begin
                        if (neg_reg)
                            acc_reg[{ci_reg, cj_reg}] <= acc_reg[{ci_reg, cj_reg}] - $signed(div_q);
                        else
                            acc_reg[{ci_reg, cj_reg}] <= acc_reg[{ci_reg, cj_reg}] + $signed(div_q);
                        {ci_reg, cj_reg} <= {ci_reg, cj_reg} + 4'd1;
                        if ({ci_reg, cj_reg} == 4'd15)
                            state_reg <= S_ACC;
                        else
                            state_reg <= S_MUL;
                    end
                S_ACC:
                begin
                    // next Gauss point, xi inner
                    if (ix_reg == 2'(n_reg - 3'd1))
                    begin
                        ix_reg <= '0;
                        if (ie_reg == 2'(n_reg - 3'd1))
                            state_reg <= S_OUT;
                        else
                        begin
                            ie_reg    <= ie_reg + 2'd1;
                            state_reg <= S_PT;
                        end
                    end
                    else
                    begin
                        ix_reg    <= ix_reg + 2'd1;
                        state_reg <= S_PT;
                    end
                end
                S_OUT:
                    if (out_ch.ready)
                    begin
                        oi_reg <= oi_reg + 4'd1;
                        if (oi_reg == 4'd15) state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### sv/quad_element_conduction_matrix.sv
//------------------------------------------------------------------------------
// quad_element_conduction_matrix: 4x4 conduction matrix of a bilinear quad
//
//   channel   dir   handshake      word
//   in_ch     in    valid/ready    eight corner coordinates, Q16.16
//   out_ch    out   valid/ready    row, col, value (Q24.24), last
//   cfg       in    cfg_we         cfg_index, cfg_data
//
// A point with non-zero determinant runs set-up, then 16 entries, each with
// six products on the shared 33x33 multiplier, divider start and 128
// divide steps; a degenerate point skips the entries and moves on.
// Reset clears the sequencer; registers return to conductivity 1.0, order 2.
// in_ch.ready is high only when idle; out_ch stalls simply hold the entry.
//------------------------------------------------------------------------------
module quad_element_conduction_matrix
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    qecm_in_if.sink     in_ch,
    qecm_out_if.source  out_ch
);
    logic [31:0] conductivity_reg;
    logic [2:0]  quad_order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conductivity_reg <= 32'd65536;
            quad_order_reg   <= 3'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qecm_pkg::REG_CONDUCTIVITY: conductivity_reg <= cfg_data;
                default:                    quad_order_reg   <= cfg_data[2:0];
            endcase
        end
    end

    qecm_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .conductivity (conductivity_reg),
        .quad_order   (quad_order_reg),
        .in_ch        (in_ch),
        .out_ch       (out_ch)
    );
endmodule
